/* sv/asn1ts_pkg.sv */
package asn1ts_pkg;

    localparam logic [7:0] TAG_UTC = 8'h17;
    localparam logic [7:0] TAG_GEN = 8'h18;
    localparam logic [7:0] LEN_UTC = 8'd13;
    localparam logic [7:0] LEN_GEN = 8'd15;
    localparam logic [7:0] CHAR_0  = 8'h30;
    localparam logic [7:0] CHAR_9  = 8'h39;
    localparam logic [7:0] CHAR_Z  = 8'h5A;

    localparam int NUM_CHARS = 15;
    localparam int NUM_LANES = 7;

    // days from 0001-01-01 to 1970-01-01
    localparam logic [23:0] DAYS_1970 = 24'd719162;
    // floor(x / 100) = (x * 5243) >> 19, exact for x < 2^14
    localparam logic [26:0] DIV100_MUL   = 27'd5243;
    localparam int          DIV100_SHIFT = 19;

    typedef struct packed {
        logic [7:0]  time_tag;
        logic [7:0]  content_length;
        logic [63:0] text_first;
        logic [55:0] text_rest;
    } asn1ts_in_t;

    typedef struct packed {
        logic        time_valid;
        logic [37:0] epoch_seconds;
    } asn1ts_out_t;

    typedef struct packed {
        logic is_utc;
        logic is_gen;
        logic len_ok;
        logic z_ok;
    } asn1ts_hdr_t;

    typedef struct packed {
        logic        ok;
        logic [13:0] year;
        logic [6:0]  month;
        logic [6:0]  day;
        logic [6:0]  hour;
        logic [6:0]  minute;
        logic [6:0]  second;
    } asn1ts_fld_t;

    typedef struct packed {
        logic        ok;
        logic [21:0] days;
        logic [16:0] tod;
    } asn1ts_cal_t;

    function automatic logic [8:0] month_start(input logic [6:0] mo);
        logic [8:0] r;
        unique case (mo)
            7'd2:    r = 9'd31;
            7'd3:    r = 9'd59;
            7'd4:    r = 9'd90;
            7'd5:    r = 9'd120;
            7'd6:    r = 9'd151;
            7'd7:    r = 9'd181;
            7'd8:    r = 9'd212;
            7'd9:    r = 9'd243;
            7'd10:   r = 9'd273;
            7'd11:   r = 9'd304;
            7'd12:   r = 9'd334;
            default: r = 9'd0;
        endcase
        return r;
    endfunction

endpackage

/* sv/asn1_time_to_epoch_seconds_top.sv */
// ASN.1 time to Unix seconds.
// Input channel item_valid/item_ready carries one word: tag byte, content
// length and up to 15 ASCII characters (UTCTime 0x17, GeneralizedTime 0x18).
// Output channel result_valid/result_ready carries one word per input:
// time_valid and epoch_seconds (zero when time_valid is low).
// Pipeline: lanes decode the seven digit pairs side by side, a merge stage
// picks the fields by format and range checks them, two calendar stages
// form the day count and time of day, and the output stage scales days by
// 86400. One word is accepted per cycle while the output is not stalled.
// A stalled output (result_valid high, result_ready low) freezes the whole
// pipeline and drops item_ready; nothing is lost or reordered.
// Reset clears all stage valid flags, so no result is shown after reset.
module asn1_time_to_epoch_seconds_top
    import asn1ts_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        item_valid,
    output logic        item_ready,
    input  asn1ts_in_t  item,
    output logic        result_valid,
    input  logic        result_ready,
    output asn1ts_out_t result
);

    logic                      adv;
    logic [3:0]                v_reg;
    logic [3:0]                v_next;
    logic                      result_valid_reg;
    logic                      result_valid_next;
    asn1ts_out_t               result_reg;
    asn1ts_out_t               result_next;

    logic [NUM_CHARS-1:0][7:0] ch;
    asn1ts_hdr_t               hdr_next;
    asn1ts_hdr_t               hdr_reg;
    logic [NUM_LANES-1:0][6:0] pair_val;
    logic [NUM_LANES-1:0]      pair_ok;
    asn1ts_fld_t               fld;
    asn1ts_cal_t               cal;
    logic [38:0]               secs;

    assign adv          = result_ready || !result_valid_reg;
    assign item_ready   = adv;
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    always_comb
    begin
        for (int i = 0; i < 8; i++)
        begin
            ch[i] = item.text_first[63 - 8*i -: 8];
        end
        for (int i = 8; i < NUM_CHARS; i++)
        begin
            ch[i] = item.text_rest[55 - 8*(i-8) -: 8];
        end
        hdr_next.is_utc = (item.time_tag == TAG_UTC);
        hdr_next.is_gen = (item.time_tag == TAG_GEN);
        hdr_next.len_ok = hdr_next.is_utc ? (item.content_length == LEN_UTC)
                                          : (item.content_length == LEN_GEN);
        hdr_next.z_ok   = hdr_next.is_utc ? (ch[12] == CHAR_Z) : (ch[14] == CHAR_Z);
    end

    genvar g;
    generate
        for (g = 0; g < NUM_LANES; g++)
        begin : g_lane
            asn1ts_lane u_lane (
                .clk     (clk),
                .en      (adv),
                .ch_hi   (ch[2*g]),
                .ch_lo   (ch[2*g+1]),
                .val_reg (pair_val[g]),
                .ok_reg  (pair_ok[g])
            );
        end
    endgenerate

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            hdr_reg <= hdr_next;
        end
    end

    asn1ts_merge u_merge (
        .clk      (clk),
        .en       (adv),
        .hdr      (hdr_reg),
        .pair_val (pair_val),
        .pair_ok  (pair_ok),
        .fld_reg  (fld)
    );

    asn1ts_cal u_cal (
        .clk     (clk),
        .en      (adv),
        .fld     (fld),
        .cal_reg (cal)
    );

    always_comb
    begin
        secs                      = ({17'b0, cal.days} * 39'd86400) + {22'b0, cal.tod};
        result_next.time_valid    = cal.ok;
        result_next.epoch_seconds = cal.ok ? secs[37:0] : 38'd0;
        v_next                    = {v_reg[2:0], item_valid};
        result_valid_next         = v_reg[3];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg            <= '0;
            result_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            v_reg            <= v_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            result_reg <= result_next;
        end
    end

    a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !result.time_valid) |-> (result.epoch_seconds == 38'd0))
        else $error("invalid result with nonzero seconds");

    a_max_seconds: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.time_valid) |-> (result.epoch_seconds <= 38'd253402300800))
        else $error("seconds beyond 9999-12-31 23:59:60");

    a_pipe_move: assert property (@(posedge clk) disable iff (!rst_n)
        adv |=> (result_valid_reg == $past(v_reg[3])))
        else $error("pipeline valid lost on advance");

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !adv |=> ($stable(v_reg) && $stable(cal)))
        else $error("pipeline moved during stall");

endmodule

/* sv/asn1ts_lane.sv */
module asn1ts_lane
    import asn1ts_pkg::*;
(
    input  logic       clk,
    input  logic       en,
    input  logic [7:0] ch_hi,
    input  logic [7:0] ch_lo,
    output logic [6:0] val_reg,
    output logic       ok_reg
);

    logic [7:0] diff_hi;
    logic [7:0] diff_lo;
    logic [6:0] val_next;
    logic       ok_next;

    always_comb
    begin
        diff_hi  = ch_hi - CHAR_0;
        diff_lo  = ch_lo - CHAR_0;
        ok_next  = (ch_hi >= CHAR_0) && (ch_hi <= CHAR_9) &&
                   (ch_lo >= CHAR_0) && (ch_lo <= CHAR_9);
        val_next = ({3'b000, diff_hi[3:0]} * 7'd10) + {3'b000, diff_lo[3:0]};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            val_reg <= val_next;
            ok_reg  <= ok_next;
        end
    end

endmodule

/* sv/asn1ts_merge.sv */
module asn1ts_merge
    import asn1ts_pkg::*;
(
    input  logic                      clk,
    input  logic                      en,
    input  asn1ts_hdr_t               hdr,
    input  logic [NUM_LANES-1:0][6:0] pair_val,
    input  logic [NUM_LANES-1:0]      pair_ok,
    output asn1ts_fld_t               fld_reg
);

    asn1ts_fld_t fld_next;
    logic        fmt_ok;
    logic        range_ok;

    always_comb
    begin
        fld_next = '0;
        if (hdr.is_utc)
        begin
            fmt_ok          = hdr.len_ok && hdr.z_ok && (&pair_ok[5:0]);
            fld_next.year   = (pair_val[0] >= 7'd50) ? 14'd1900 + {7'b0, pair_val[0]}
                                                      : 14'd2000 + {7'b0, pair_val[0]};
            fld_next.month  = pair_val[1];
            fld_next.day    = pair_val[2];
            fld_next.hour   = pair_val[3];
            fld_next.minute = pair_val[4];
            fld_next.second = pair_val[5];
        end
        else
        begin
            fmt_ok          = hdr.is_gen && hdr.len_ok && hdr.z_ok && (&pair_ok);
            fld_next.year   = ({7'b0, pair_val[0]} * 14'd100) + {7'b0, pair_val[1]};
            fld_next.month  = pair_val[2];
            fld_next.day    = pair_val[3];
            fld_next.hour   = pair_val[4];
            fld_next.minute = pair_val[5];
            fld_next.second = pair_val[6];
        end
        range_ok = (fld_next.year >= 14'd1970) &&
                   (fld_next.month >= 7'd1) && (fld_next.month <= 7'd12) &&
                   (fld_next.day >= 7'd1) && (fld_next.day <= 7'd31) &&
                   (fld_next.hour <= 7'd23) && (fld_next.minute <= 7'd59) &&
                   (fld_next.second <= 7'd60);
        fld_next.ok = fmt_ok && range_ok;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            fld_reg <= fld_next;
        end
    end

endmodule

/* sv/asn1ts_cal.sv */
module asn1ts_cal
    import asn1ts_pkg::*;
(
    input  logic        clk,
    input  logic        en,
    input  asn1ts_fld_t fld,
    output asn1ts_cal_t cal_reg
);

    // stage A: year - 1 and the divisions by 100
    logic [13:0] p_next;
    logic [26:0] p_prod;
    logic [26:0] y_prod;
    logic [13:0] p_reg;
    logic [6:0]  pq_reg;
    logic [6:0]  yq_reg;
    asn1ts_fld_t f_reg;

    // stage B: day count and time of day
    logic [13:0] y_cent;
    logic        leap;
    logic [23:0] leap_add;
    logic [23:0] days_sum;
    logic [16:0] tod_sum;
    asn1ts_cal_t cal_next;

    always_comb
    begin
        p_next = fld.year - 14'd1;
        p_prod = {13'b0, p_next} * DIV100_MUL;
        y_prod = {13'b0, fld.year} * DIV100_MUL;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_reg  <= p_next;
            pq_reg <= p_prod[DIV100_SHIFT +: 7];
            yq_reg <= y_prod[DIV100_SHIFT +: 7];
            f_reg  <= fld;
        end
    end

    always_comb
    begin
        y_cent   = {7'b0, yq_reg} * 14'd100;
        leap     = (f_reg.year[1:0] == 2'b00) &&
                   ((f_reg.year != y_cent) || (yq_reg[1:0] == 2'b00));
        leap_add = (leap && (f_reg.month > 7'd2)) ? 24'd1 : 24'd0;
        days_sum = ({10'b0, p_reg} * 24'd365) + {12'b0, p_reg[13:2]}
                 - {17'b0, pq_reg} + {19'b0, pq_reg[6:2]}
                 + {15'b0, month_start(f_reg.month)} + {17'b0, f_reg.day} - 24'd1
                 + leap_add - DAYS_1970;
        tod_sum  = ({10'b0, f_reg.hour} * 17'd3600) + ({10'b0, f_reg.minute} * 17'd60)
                 + {10'b0, f_reg.second};
        cal_next.ok   = f_reg.ok;
        cal_next.days = days_sum[21:0];
        cal_next.tod  = tod_sum;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cal_reg <= cal_next;
        end
    end

endmodule
